// ===== rtl/core/dpbp_pkg.sv =====
// ============================================================================
// Depth pixel back-projection package
// Word types, widths and register indexes shared by the back-projection core.
// ============================================================================
package dpbp_pkg;

    // Pixel coordinates are reduced to this many low bits before use.
    localparam int COORD_BITS = 12;

    // Field widths
    localparam int COL_W   = 12;
    localparam int DEPTH_W = 16;
    localparam int PP_W    = 20;
    localparam int INV_W   = 25;
    localparam int XY_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Datapath widths
    localparam int SCALED_W = COORD_BITS + 8;
    localparam int DIFF_W   = (SCALED_W > PP_W) ? SCALED_W : PP_W;
    localparam int MAG_W    = DIFF_W + DEPTH_W;
    localparam int MLO_W    = 18;
    localparam int MHI_W    = MAG_W - MLO_W;
    localparam int PLO_W    = MLO_W + INV_W;
    localparam int PHI_W    = MHI_W + INV_W;
    localparam int PROD_W   = MAG_W + INV_W;
    localparam int FRAC_W   = 32;
    localparam int Q_W      = PROD_W - FRAC_W;
    localparam int QX_W     = (Q_W > XY_W + 1) ? Q_W : XY_W + 1;

    localparam logic [QX_W-1:0] MAG_POS_MAX = QX_W'(64'h0000_0000_7FFF_FFFF);
    localparam logic [QX_W-1:0] MAG_NEG_MAX = QX_W'(64'h0000_0000_8000_0000);
    localparam logic [XY_W-1:0] XY_POS_SAT  = 32'h7FFF_FFFF;
    localparam logic [XY_W-1:0] XY_NEG_SAT  = 32'h8000_0000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRINCIPAL_COL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRINCIPAL_ROW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y   = 2'd3;

    // Register reset values
    localparam logic [PP_W-1:0]  PRINCIPAL_COL_RST = 20'd67111;
    localparam logic [PP_W-1:0]  PRINCIPAL_ROW_RST = 20'd52652;
    localparam logic [INV_W-1:0] INV_FOCAL_X_RST   = 25'd45966;
    localparam logic [INV_W-1:0] INV_FOCAL_Y_RST   = 25'd45966;

    typedef struct packed {
        logic [COL_W-1:0]   pixel_col;
        logic [COL_W-1:0]   pixel_row;
        logic [DEPTH_W-1:0] depth_raw;
    } t_in_word;

    typedef struct packed {
        logic signed [XY_W-1:0] point_x;
        logic signed [XY_W-1:0] point_y;
        logic [DEPTH_W-1:0]     point_z;
        logic                   point_valid;
    } t_out_word;

    // Load enables of the four datapath stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

endpackage

// ===== rtl/core/dpbp_axis.sv =====
// ============================================================================
// Back-projection axis datapath
// Four-stage path for one axis: offset from principal point, depth product,
// split reciprocal product, sum and scale, then sign and saturation.
// ============================================================================
module dpbp_axis (
    input  logic                      i_clk,
    input  dpbp_pkg::t_stage_en       i_en,
    input  logic [dpbp_pkg::COL_W-1:0]   i_coord,
    input  logic [dpbp_pkg::PP_W-1:0]    i_pp,
    input  logic [dpbp_pkg::INV_W-1:0]   i_inv,
    input  logic [dpbp_pkg::DEPTH_W-1:0] i_z,
    output logic signed [dpbp_pkg::XY_W-1:0] o_coord
);
    import dpbp_pkg::*;

    localparam logic [COL_W-1:0] CMASK = COL_W'((64'd1 << COORD_BITS) - 64'd1);

    logic [COL_W-1:0]  masked;
    logic [DIFF_W-1:0] scaled;
    logic [DIFF_W-1:0] pp_ext;
    logic              n_neg;
    logic [DIFF_W-1:0] n_diff;
    logic [PROD_W-1:0] n_sum;
    logic [QX_W-1:0]   qx;

    logic [DIFF_W-1:0] r_diff;
    logic              r_neg1, r_neg2, r_neg3, r_neg4;
    logic [MAG_W-1:0]  r_mag;
    logic [PLO_W-1:0]  r_plo;
    logic [PHI_W-1:0]  r_phi;
    logic [Q_W-1:0]    r_q;

    // stage 1: |coord*256 - pp|
    assign masked = i_coord & CMASK;
    assign scaled = DIFF_W'({masked, 8'h00});
    assign pp_ext = DIFF_W'(i_pp);
    assign n_neg  = scaled < pp_ext;
    assign n_diff = n_neg ? (pp_ext - scaled) : (scaled - pp_ext);

    // stage 4: full product, floor by 2^32
    assign n_sum = PROD_W'(r_plo) + (PROD_W'(r_phi) << MLO_W);

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_diff <= n_diff;
            r_neg1 <= n_neg;
        end
        if (i_en.s2) begin
            r_mag  <= MAG_W'(r_diff) * MAG_W'(i_z);
            r_neg2 <= r_neg1;
        end
        if (i_en.s3) begin
            r_plo  <= PLO_W'(r_mag[MLO_W-1:0]) * PLO_W'(i_inv);
            r_phi  <= PHI_W'(r_mag[MAG_W-1:MLO_W]) * PHI_W'(i_inv);
            r_neg3 <= r_neg2;
        end
        if (i_en.s4) begin
            r_q    <= n_sum[PROD_W-1:FRAC_W];
            r_neg4 <= r_neg3;
        end
    end

    // sign and saturate
    assign qx = QX_W'(r_q);
    always_comb begin
        if (r_neg4) begin
            if (qx > MAG_NEG_MAX) begin
                o_coord = XY_NEG_SAT;
            end else begin
                o_coord = XY_W'(0) - qx[XY_W-1:0];
            end
        end else begin
            if (qx > MAG_POS_MAX) begin
                o_coord = XY_POS_SAT;
            end else begin
                o_coord = qx[XY_W-1:0];
            end
        end
    end

endmodule

// ===== rtl/core/depth_pixel_backprojection_unit.sv =====
// ============================================================================
// Depth pixel back-projection unit
// Pinhole back-projection of a depth pixel into a camera-space point.
// ============================================================================
//
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_stall | t_in_word  (col, row, depth)
//  out     | output    | o_out_valid/ i_out_stall| t_out_word (x, y, z, valid)
//  cfg     | input     | i_cfg_valid/ o_cfg_ready| index + data, always ready
//
//  Five register stages: offset, depth product, split reciprocal product,
//  sum and scale, output register. One word per cycle while the output is not stalled.
//  Each stage loads whenever it is empty or the stage after it moves, so
//  bubbles close up while the output waits; o_in_stall rises only when all
//  stages are full and the output word is stalled.
//  Reset (i_rst_n low, synchronous) empties the pipe and loads the camera
//  defaults into the configuration registers.
//
module depth_pixel_backprojection_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  dpbp_pkg::t_in_word         i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output dpbp_pkg::t_out_word        o_out_word,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [dpbp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dpbp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dpbp_pkg::*;

    // configuration registers
    logic [PP_W-1:0]  r_pp_col, r_pp_row;
    logic [INV_W-1:0] r_inv_x, r_inv_y;

    // valid bits of stages 1..4 and depth carried alongside
    logic [3:0]         r_vld;
    logic [DEPTH_W-1:0] r_z1, r_z2, r_z3, r_z4;
    logic               r_out_valid;
    t_out_word          r_out_word;
    t_out_word          n_out_word;

    // ready to load, per stage; index 4 is the output register
    logic [4:0] rdy;
    t_stage_en  en;

    logic signed [XY_W-1:0] coord_x, coord_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_col <= PRINCIPAL_COL_RST;
            r_pp_row <= PRINCIPAL_ROW_RST;
            r_inv_x  <= INV_FOCAL_X_RST;
            r_inv_y  <= INV_FOCAL_Y_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PRINCIPAL_COL: r_pp_col <= i_cfg_data[PP_W-1:0];
                CFG_PRINCIPAL_ROW: r_pp_row <= i_cfg_data[PP_W-1:0];
                CFG_INV_FOCAL_X:   r_inv_x  <= i_cfg_data[INV_W-1:0];
                CFG_INV_FOCAL_Y:   r_inv_y  <= i_cfg_data[INV_W-1:0];
                default: ;
            endcase
        end
    end

    // Backward ready chain: a stage loads when empty or when its successor loads.
    assign rdy[4] = !r_out_valid || !i_out_stall;
    assign rdy[3] = !r_vld[3] || rdy[4];
    assign rdy[2] = !r_vld[2] || rdy[3];
    assign rdy[1] = !r_vld[1] || rdy[2];
    assign rdy[0] = !r_vld[0] || rdy[1];

    assign en.s1 = rdy[0];
    assign en.s2 = rdy[1];
    assign en.s3 = rdy[2];
    assign en.s4 = rdy[3];

    assign o_in_stall = !rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy[0]) r_vld[0] <= i_in_valid;
            if (rdy[1]) r_vld[1] <= r_vld[0];
            if (rdy[2]) r_vld[2] <= r_vld[1];
            if (rdy[3]) r_vld[3] <= r_vld[2];
            if (rdy[4]) r_out_valid <= r_vld[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en.s1) r_z1 <= i_in_word.depth_raw;
        if (en.s2) r_z2 <= r_z1;
        if (en.s3) r_z3 <= r_z2;
        if (en.s4) r_z4 <= r_z3;
        if (rdy[4]) r_out_word <= n_out_word;
    end

    dpbp_axis u_axis_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (i_in_word.pixel_col),
        .i_pp    (r_pp_col),
        .i_inv   (r_inv_x),
        .i_z     (r_z1),
        .o_coord (coord_x)
    );

    dpbp_axis u_axis_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (i_in_word.pixel_row),
        .i_pp    (r_pp_row),
        .i_inv   (r_inv_y),
        .i_z     (r_z1),
        .o_coord (coord_y)
    );

    // Zero depth: whole point is zero and the valid flag drops.
    always_comb begin
        if (r_z4 == '0) begin
            n_out_word = '0;
        end else begin
            n_out_word.point_x     = coord_x;
            n_out_word.point_y     = coord_y;
            n_out_word.point_z     = r_z4;
            n_out_word.point_valid = 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // ------------------------------------------------------------------------
    a_valid_has_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.point_valid == (o_out_word.point_z != '0)))
        else $error("point_valid does not match depth");

    a_no_depth_zero_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.point_valid) |->
            (o_out_word.point_x == '0 && o_out_word.point_y == '0))
        else $error("zero-depth word carries a nonzero point");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_vld == 4'hF && r_out_valid && i_out_stall))
        else $error("input stalled with room in the pipe");

    a_held_word_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled output word dropped");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Back-projection unit testbench
// Sends depth pixels through the unit under several camera settings: first a
// short directed table, then random phases with register writes between them.
// Every output word is checked against a scoreboard of expected points that
// is fed by a bit-exact projection predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import dpbp_pkg::*;

    localparam int PIPE_LATENCY = 5;    // stages from input to output word
    localparam int PHASES       = 6;
    localparam int PHASE_WORDS  = 75;   // about 450 random pixels in total

    // Clock, reset and all block inputs start at known values
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_word    i_in_word   = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_word   o_out_word;
    logic        o_cfg_ready;

    depth_pixel_backprojection_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Camera settings as the testbench believes them to be
    logic [PP_W-1:0]  cam_center_col;
    logic [PP_W-1:0]  cam_center_row;
    logic [INV_W-1:0] cam_inv_fx;
    logic [INV_W-1:0] cam_inv_fy;

    t_out_word expected_points[$];
    int        mismatches = 0;
    bit        steady     = 1'b0;   // no gaps and no stalls while set

    // One row of the directed table: a pixel word or a register write
    typedef enum logic {ROW_PIXEL, ROW_REG} t_row_kind;
    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_data;
        t_in_word              pixel;
        bit                    known;   // expected word typed in below
        t_out_word             want;
    } t_plan_row;

    // ------------------------------------------------------------------
    // Projection predictor
    // ------------------------------------------------------------------

    // (coord*256 - center) * z * inv / 2^32, truncated toward zero, saturated
    function automatic logic signed [XY_W-1:0] axis_coord(
        logic [COL_W-1:0] coord, logic [PP_W-1:0] center_q8,
        logic [DEPTH_W-1:0] z, logic [INV_W-1:0] inv_q24);
        logic [63:0] scaled;
        logic [63:0] center;
        logic [63:0] diff;
        logic [63:0] mag;
        logic [63:0] part;
        logic [63:0] q;
        logic        neg;
        scaled = (64'(coord) & ((64'd1 << COORD_BITS) - 64'd1)) << 8;
        center = 64'(center_q8);
        neg    = scaled < center;
        diff   = neg ? center - scaled : scaled - center;
        mag    = diff * 64'(z);
        // split reciprocal keeps every partial product well inside 64 bits
        part   = mag * 64'(inv_q24[INV_W-1:16]) + ((mag * 64'(inv_q24[15:0])) >> 16);
        q      = part >> 16;
        if (neg) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return XY_W'(0) - q[XY_W-1:0];
        end
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return q[XY_W-1:0];
    endfunction

    function automatic t_out_word project_pixel(t_in_word w);
        t_out_word p;
        p = '0;
        if (w.depth_raw != '0) begin
            p.point_x     = axis_coord(w.pixel_col, cam_center_col, w.depth_raw, cam_inv_fx);
            p.point_y     = axis_coord(w.pixel_row, cam_center_row, w.depth_raw, cam_inv_fy);
            p.point_z     = w.depth_raw;
            p.point_valid = 1'b1;
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Waits for the pipe to empty, then for its latency, before any write
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_PRINCIPAL_COL: cam_center_col = data[PP_W-1:0];
            CFG_PRINCIPAL_ROW: cam_center_row = data[PP_W-1:0];
            CFG_INV_FOCAL_X:   cam_inv_fx     = data[INV_W-1:0];
            CFG_INV_FOCAL_Y:   cam_inv_fy     = data[INV_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Leaves valid high after the word is taken; the next call or drain decides
    task automatic send_pixel(t_in_word w, bit known, t_out_word want);
        if (!steady && $urandom_range(0, 99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_points = {expected_points, (known ? want : project_pixel(w))};
    endtask

    // Receiver raises a stall at random about 7 times in 100, never while steady
    always @(posedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(0, 99) < 7);
    end

    // ------------------------------------------------------------------
    // Output checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_out
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_points.size() == 0) begin
                $error("point word with none expected: x %0d y %0d z %0d valid %0b",
                       o_out_word.point_x, o_out_word.point_y,
                       o_out_word.point_z, o_out_word.point_valid);
                mismatches++;
            end else begin
                want = expected_points.pop_front();
                if (o_out_word.point_x !== want.point_x) begin
                    $error("point_x: expected %0d, got %0d", want.point_x, o_out_word.point_x);
                    mismatches++;
                end
                if (o_out_word.point_y !== want.point_y) begin
                    $error("point_y: expected %0d, got %0d", want.point_y, o_out_word.point_y);
                    mismatches++;
                end
                if (o_out_word.point_z !== want.point_z) begin
                    $error("point_z: expected %0d, got %0d", want.point_z, o_out_word.point_z);
                    mismatches++;
                end
                if (o_out_word.point_valid !== want.point_valid) begin
                    $error("point_valid: expected %0b, got %0b",
                           want.point_valid, o_out_word.point_valid);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Table rows and random values
    // ------------------------------------------------------------------
    function automatic t_plan_row pixel_row(int col, int row, int depth);
        t_plan_row r;
        r.kind      = ROW_PIXEL;
        r.reg_index = '0;
        r.reg_data  = '0;
        r.pixel     = '{pixel_col: COL_W'(col), pixel_row: COL_W'(row),
                        depth_raw: DEPTH_W'(depth)};
        r.known     = 1'b0;
        r.want      = '0;
        return r;
    endfunction

    function automatic t_plan_row known_row(int col, int row, int depth,
                                           int x, int y, int z, bit v);
        t_plan_row r;
        r       = pixel_row(col, row, depth);
        r.known = 1'b1;
        r.want  = '{point_x: XY_W'(x), point_y: XY_W'(y),
                    point_z: DEPTH_W'(z), point_valid: v};
        return r;
    endfunction

    function automatic t_plan_row reg_row(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
        t_plan_row r;
        r           = pixel_row(0, 0, 0);
        r.kind      = ROW_REG;
        r.reg_index = idx;
        r.reg_data  = data;
        return r;
    endfunction

    // Principal point: mostly in range, sometimes the edges, sometimes junk high bits
    function automatic logic [CFG_DATA_W-1:0] pick_center();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 32'h000F_FFFF;
            2:       return $urandom();
            default: return $urandom_range(0, 4095 * 256);
        endcase
    endfunction

    // Reciprocal focal length: realistic lenses, plus zero, unity and all ones
    function automatic logic [CFG_DATA_W-1:0] pick_inv_focal();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'h0100_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return $urandom();
            default: return $urandom_range(5000, 200000);
        endcase
    endfunction

    function automatic t_in_word random_pixel();
        t_in_word w;
        w.pixel_col = ($urandom_range(0, 19) == 0) ? {COL_W{$urandom_range(0, 1) == 1}}
                                                   : COL_W'($urandom());
        w.pixel_row = ($urandom_range(0, 19) == 0) ? {COL_W{$urandom_range(0, 1) == 1}}
                                                   : COL_W'($urandom());
        case ($urandom_range(0, 19))
            0, 1:    w.depth_raw = '0;          // no depth at this pixel
            2:       w.depth_raw = '1;
            3:       w.depth_raw = DEPTH_W'(1);
            default: w.depth_raw = DEPTH_W'($urandom_range(1, 65535));
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_plan_row plan[$];
        bit        after_write;
        plan = {};
        after_write = 1'b0;

        // Reset camera: zero depth, extremes of both coordinates and depth
        plan = {plan, known_row(0, 0, 0, 0, 0, 0, 1'b0)};
        plan = {plan, pixel_row(4095, 4095, 65535)};
        plan = {plan, pixel_row(0, 0, 1)};
        plan = {plan, pixel_row(4095, 0, 65535)};
        plan = {plan, pixel_row(0, 4095, 1234)};
        plan = {plan, pixel_row(262, 205, 5000)};
        plan = {plan, known_row(4095, 4095, 0, 0, 0, 0, 1'b0)};
        // Unity focal length: X = col * Z exactly, Y at its most negative
        plan = {plan, reg_row(CFG_PRINCIPAL_COL, 32'h0000_0000)};
        plan = {plan, reg_row(CFG_PRINCIPAL_ROW, 32'h000F_FFFF)};
        plan = {plan, reg_row(CFG_INV_FOCAL_X,   32'h0100_0000)};
        plan = {plan, reg_row(CFG_INV_FOCAL_Y,   32'h0100_0000)};
        plan = {plan, known_row(4095, 0, 65535, 268365825, -268431104, 65535, 1'b1)};
        // tiny negative offset truncates to zero, not to -1
        plan = {plan, known_row(0, 4095, 1, 0, 0, 1, 1'b1)};
        plan = {plan, pixel_row(1, 4095, 1)};
        // All-ones writes: registers keep only their own width
        plan = {plan, reg_row(CFG_PRINCIPAL_COL, 32'hFFFF_FFFF)};
        plan = {plan, reg_row(CFG_PRINCIPAL_ROW, 32'hFFFF_FFFF)};
        plan = {plan, reg_row(CFG_INV_FOCAL_X,   32'hFFFF_FFFF)};
        plan = {plan, reg_row(CFG_INV_FOCAL_Y,   32'hFFFF_FFFF)};
        plan = {plan, pixel_row(0, 0, 65535)};
        plan = {plan, pixel_row(4095, 4095, 65535)};
        // Zero reciprocal focal length flattens both axes
        plan = {plan, reg_row(CFG_INV_FOCAL_X, 32'h0000_0000)};
        plan = {plan, reg_row(CFG_INV_FOCAL_Y, 32'h0000_0000)};
        plan = {plan, known_row(100, 200, 7777, 0, 0, 7777, 1'b1)};
        plan = {plan, known_row(4095, 0, 65535, 0, 0, 65535, 1'b1)};
        // Pixel exactly on the principal point
        plan = {plan, reg_row(CFG_PRINCIPAL_COL, 32'd25600)};
        plan = {plan, reg_row(CFG_PRINCIPAL_ROW, 32'd51200)};
        plan = {plan, reg_row(CFG_INV_FOCAL_X,   32'd1)};
        plan = {plan, reg_row(CFG_INV_FOCAL_Y,   32'h0100_0000)};
        plan = {plan, known_row(100, 200, 65535, 0, 0, 65535, 1'b1)};
        plan = {plan, pixel_row(101, 201, 65535)};
        plan = {plan, pixel_row(99, 199, 65535)};

        cam_center_col = PRINCIPAL_COL_RST;
        cam_center_row = PRINCIPAL_ROW_RST;
        cam_inv_fx     = INV_FOCAL_X_RST;
        cam_inv_fy     = INV_FOCAL_Y_RST;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                if (!after_write) drain();
                write_reg(plan[i].reg_index, plan[i].reg_data);
                after_write = 1'b1;
            end else begin
                send_pixel(plan[i].pixel, plan[i].known, plan[i].want);
                after_write = 1'b0;
            end
        end

        // Random phases; the sender waits for every point before each new camera
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            steady = (ph == 2);
            write_reg(CFG_PRINCIPAL_COL, pick_center());
            write_reg(CFG_PRINCIPAL_ROW, pick_center());
            write_reg(CFG_INV_FOCAL_X,   pick_inv_focal());
            write_reg(CFG_INV_FOCAL_Y,   pick_inv_focal());
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_pixel(random_pixel(), 1'b0, '0);
            end
        end

        steady = 1'b0;
        drain();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #200000;
        $display("FAIL");
        $finish;
    end

endmodule
